// ===== rtl/io_card_encoder_counter_device_top_macros.svh =====
// ----------------------------------------------------------------------------
// I/O card assertion macros
// Short forms for the concurrent checks on the I/O card ports.
// ----------------------------------------------------------------------------
`ifndef IO_CARD_ENCODER_COUNTER_DEVICE_TOP_MACROS_SVH
`define IO_CARD_ENCODER_COUNTER_DEVICE_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define IOC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ioc check failed");

// Next-cycle implication, held off while reset is asserted.
`define IOC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ioc check failed");

`endif

// ===== rtl/ioc_pkg.sv =====
// ----------------------------------------------------------------------------
// I/O card package
// Widths, function codes, limits and the request and result records.
// ----------------------------------------------------------------------------
package ioc_pkg;

	localparam int OUTPUT_CHANNELS = 32;

	localparam int WORD_W = 32;
	localparam int POS_W  = 12;
	localparam int CNT_W  = 16;
	localparam int FUNC_W = 3;
	localparam int SEL_W  = 2;
	localparam int BIT_W  = 5;
	localparam int EDGE_DEPTH = 32;

	localparam logic [POS_W-1:0] DIFF_LIMIT  = POS_W'(2000);
	localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(16'h7fff);
	localparam logic [SEL_W-1:0] SEL_COUNTER0 = '0;

	localparam logic [FUNC_W-1:0] FUNC_WR_OUT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET_IN  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_ENC_POS = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_WR_CNT  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RD_CNT  = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_RD_EDGE = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RD_IN   = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_PULSE   = 3'd7;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [WORD_W-1:0] data;
		logic [WORD_W-1:0] write_mask;
		logic [SEL_W-1:0]  counter_select;
		logic [BIT_W-1:0]  bit_index;
	} ioc_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [WORD_W-1:0] output_word;
		logic              irq_digital_input;
		logic              irq_encoder;
		logic              irq_pulse;
		logic              counter_ready;
	} ioc_result_t;

endpackage

// ===== rtl/io_card_encoder_counter_device_top.sv =====
// ----------------------------------------------------------------------------
// I/O card with encoder down-counter
// Request/result wrapper: input register, combinational core, result register.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the in_valid/in_ready channel with func, data,
// write_mask, counter_select and bit_index; each request gives exactly one
// result on the out_valid/out_ready channel, in order.
// A request accepted into the input register is evaluated by the core there,
// and the result register captures the result once it is empty or being read.
// Throughput is one request per cycle while the receiver takes each result,
// set by the single pass through the core between the two registers.
// When the receiver stalls, the held result stays stable and one further
// request may still be accepted into the input register; after that,
// in_ready falls until the result is taken.
// The interrupt mask is written through cfg_write_en/cfg_write_data, to be
// done only while the block is idle.
// Reset clears every state register, all edge counters and the mask, and
// leaves both stages empty, so in_ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module io_card_encoder_counter_device_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ioc_pkg::FUNC_W-1:0] func,
	input  logic [ioc_pkg::WORD_W-1:0] data,
	input  logic [ioc_pkg::WORD_W-1:0] write_mask,
	input  logic [ioc_pkg::SEL_W-1:0]  counter_select,
	input  logic [ioc_pkg::BIT_W-1:0]  bit_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ioc_pkg::WORD_W-1:0] read_data,
	output logic [ioc_pkg::WORD_W-1:0] output_word,
	output logic                       irq_digital_input,
	output logic                       irq_encoder,
	output logic                       irq_pulse,
	output logic                       counter_ready,
	input  logic                       cfg_write_en,
	input  logic [ioc_pkg::WORD_W-1:0] cfg_write_data
);
	import ioc_pkg::*;

	logic        valid_s1;
	ioc_item_t   item_s1;
	logic        out_valid_q;
	ioc_result_t res_q;
	ioc_result_t res_comb;
	logic        advance;
	logic        step;

	// The result register can take a new value when it is empty or being read.
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.func           <= func;
			item_s1.data           <= data;
			item_s1.write_mask     <= write_mask;
			item_s1.counter_select <= counter_select;
			item_s1.bit_index      <= bit_index;
		end
	end

	ioc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.item          (item_s1),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.result        (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_comb;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_data         = res_q.read_data;
	assign output_word       = res_q.output_word;
	assign irq_digital_input = res_q.irq_digital_input;
	assign irq_encoder       = res_q.irq_encoder;
	assign irq_pulse         = res_q.irq_pulse;
	assign counter_ready     = res_q.counter_ready;

endmodule

// ===== rtl/ioc_edge_bank.sv =====
// ----------------------------------------------------------------------------
// I/O card edge counter bank
// One wrapping falling-edge counter per output channel, with a read port.
// ----------------------------------------------------------------------------
module ioc_edge_bank (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ioc_pkg::WORD_W-1:0] fell,
	input  logic [ioc_pkg::BIT_W-1:0]  rd_index,
	output logic [ioc_pkg::WORD_W-1:0] rd_count
);
	import ioc_pkg::*;

	logic [WORD_W-1:0] cnt_q [EDGE_DEPTH];

	// Channels beyond the configured count have no counter and read as zero.
	for (genvar i = 0; i < EDGE_DEPTH; i++) begin : g_cnt
		if (i < OUTPUT_CHANNELS) begin : g_live
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q[i] <= '0;
				end else if (fell[i]) begin
					cnt_q[i] <= cnt_q[i] + WORD_W'(1);
				end
			end
		end else begin : g_none
			assign cnt_q[i] = '0;
		end
	end

	assign rd_count = cnt_q[rd_index];

endmodule

// ===== rtl/ioc_core.sv =====
// ----------------------------------------------------------------------------
// I/O card core
// Card state and the combinational evaluation of one request.
// ----------------------------------------------------------------------------
module ioc_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  ioc_pkg::ioc_item_t         item,
	input  logic                       cfg_write_en,
	input  logic [ioc_pkg::WORD_W-1:0] cfg_write_data,
	output ioc_pkg::ioc_result_t       result
);
	import ioc_pkg::*;

	logic [WORD_W-1:0] irq_mask_q;
	logic [WORD_W-1:0] out_bits_q, out_bits_nxt;
	logic [WORD_W-1:0] in_bits_q, in_bits_nxt;
	logic [CNT_W-1:0]  enc_cnt_q, enc_cnt_nxt;
	logic [POS_W-1:0]  last_pos_q, last_pos_nxt;
	logic              ready_q, ready_nxt;

	logic [WORD_W-1:0] fell;
	logic [WORD_W-1:0] edge_rd;
	logic [POS_W-1:0]  diff;
	logic [CNT_W-1:0]  sub_cnt;
	logic [WORD_W-1:0] rd;
	logic              irq_di, enc_hit, irq_pl, any_irq;

	ioc_edge_bank u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.fell    (fell & {WORD_W{step}}),
		.rd_index(item.bit_index),
		.rd_count(edge_rd)
	);

	always_comb begin
		out_bits_nxt = out_bits_q;
		in_bits_nxt  = in_bits_q;
		enc_cnt_nxt  = enc_cnt_q;
		last_pos_nxt = last_pos_q;
		ready_nxt    = ready_q;
		fell         = '0;
		rd           = '0;
		irq_di       = 1'b0;
		enc_hit      = 1'b0;
		irq_pl       = 1'b0;
		// Forward difference wraps at the 12-bit position range.
		diff    = item.data[POS_W-1:0] - last_pos_q;
		sub_cnt = enc_cnt_q - CNT_W'(diff);
		case (item.func)
			FUNC_WR_OUT: begin
				out_bits_nxt = (item.data & item.write_mask) | (~item.write_mask & out_bits_q);
				fell         = out_bits_q & ~out_bits_nxt;
			end
			FUNC_SET_IN: begin
				irq_di      = (item.data & irq_mask_q) != (in_bits_q & irq_mask_q);
				in_bits_nxt = item.data;
			end
			FUNC_ENC_POS: begin
				if (diff < DIFF_LIMIT) begin
					enc_cnt_nxt = sub_cnt;
					if (sub_cnt > COUNT_LIMIT) begin
						ready_nxt = 1'b1;
						enc_hit   = 1'b1;
					end
				end
				last_pos_nxt = item.data[POS_W-1:0];
			end
			FUNC_WR_CNT: begin
				if (item.counter_select == SEL_COUNTER0) begin
					ready_nxt   = 1'b0;
					enc_cnt_nxt = item.data[CNT_W-1:0];
				end
			end
			FUNC_RD_CNT: begin
				if (item.counter_select == SEL_COUNTER0) begin
					rd = WORD_W'(enc_cnt_q);
				end
			end
			FUNC_RD_EDGE: begin
				rd = edge_rd;
			end
			FUNC_RD_IN: begin
				rd = in_bits_q;
			end
			FUNC_PULSE: begin
				irq_pl = 1'b1;
			end
			default: begin
				irq_pl = 1'b0;
			end
		endcase
		any_irq = irq_di | enc_hit | irq_pl;

		result.read_data         = rd;
		result.output_word       = out_bits_nxt;
		result.irq_digital_input = irq_di;
		// While the counter is ready, any interrupt also signals the encoder.
		result.irq_encoder       = enc_hit | (any_irq & ready_nxt);
		result.irq_pulse         = irq_pl;
		result.counter_ready     = ready_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_mask_q <= '0;
		end else if (cfg_write_en) begin
			irq_mask_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bits_q <= '0;
			in_bits_q  <= '0;
			enc_cnt_q  <= '0;
			last_pos_q <= '0;
			ready_q    <= 1'b0;
		end else if (step) begin
			out_bits_q <= out_bits_nxt;
			in_bits_q  <= in_bits_nxt;
			enc_cnt_q  <= enc_cnt_nxt;
			last_pos_q <= last_pos_nxt;
			ready_q    <= ready_nxt;
		end
	end

endmodule

// ===== rtl/ioc_checker.sv =====
// ----------------------------------------------------------------------------
// I/O card port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "io_card_encoder_counter_device_top_macros.svh"

module ioc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ioc_pkg::WORD_W-1:0] read_data,
	input logic [ioc_pkg::WORD_W-1:0] output_word,
	input logic                       irq_digital_input,
	input logic                       irq_encoder,
	input logic                       irq_pulse,
	input logic                       counter_ready
);
	import ioc_pkg::*;

	// A stalled result holds its payload.
	`IOC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(output_word))

	// One request cannot be both an input change and a pulse tick.
	`IOC_ASSERT_NOW(a_irq_excl, clk, arst_n, out_valid, !(irq_digital_input && irq_pulse))

	// Requests that raise input or pulse interrupts are never reads.
	`IOC_ASSERT_NOW(a_irq_no_read, clk, arst_n, out_valid && (irq_digital_input || irq_pulse), read_data == '0)

	// An encoder interrupt only ever comes with the ready flag set.
	`IOC_ASSERT_NOW(a_enc_ready, clk, arst_n, out_valid && irq_encoder, counter_ready)

endmodule

bind io_card_encoder_counter_device_top ioc_checker u_ioc_checker (.*);

// ===== dv/io_card_encoder_counter_device_top_tb.sv =====
// ----------------------------------------------------------------------------
// I/O card with encoder down-counter: testbench
// Drives requests through the request/result channels with random gaps and
// back-pressure, predicts every result from an internal model of the card,
// and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module io_card_encoder_counter_device_top_tb;

	import ioc_pkg::*;

	// Generous bound on the whole run; the slowest legal run is far shorter.
	localparam int CYCLE_LIMIT = 600000;
	// Length of the deliberate receiver hold-off used to fill the block.
	localparam int HOLD_CYCLES = 60;
	// Cycles allowed after the last result before the block counts as idle.
	localparam int SETTLE_CYCLES = 4;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [FUNC_W-1:0] func;
	logic [WORD_W-1:0] data;
	logic [WORD_W-1:0] write_mask;
	logic [SEL_W-1:0]  counter_select;
	logic [BIT_W-1:0]  bit_index;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] read_data;
	logic [WORD_W-1:0] output_word;
	logic              irq_digital_input;
	logic              irq_encoder;
	logic              irq_pulse;
	logic              counter_ready;
	logic              cfg_write_en;
	logic [WORD_W-1:0] cfg_write_data;

	io_card_encoder_counter_device_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.data             (data),
		.write_mask       (write_mask),
		.counter_select   (counter_select),
		.bit_index        (bit_index),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.read_data        (read_data),
		.output_word      (output_word),
		.irq_digital_input(irq_digital_input),
		.irq_encoder      (irq_encoder),
		.irq_pulse        (irq_pulse),
		.counter_ready    (counter_ready),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data)
	);

	// Clock: six units high, six units low.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Model of the card. It is updated only by the monitor below, at the
	// rising edges where a request or a mask write is taken, so its order
	// of updates is the order in which the block sees them.
	// ------------------------------------------------------------------
	logic [WORD_W-1:0] card_mask;
	logic [WORD_W-1:0] card_out;
	logic [WORD_W-1:0] card_in;
	logic [WORD_W-1:0] card_edges [EDGE_DEPTH];
	logic [CNT_W-1:0]  card_count;
	logic [POS_W-1:0]  card_last_pos;
	logic              card_ready;

	ioc_result_t due_results [$];
	int          mismatches;
	int          cycles;

	// Idling controls of the sender and the receiver; the tests set the enables and the hold request.
	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_request;
	int hold_left;
	int rx_gap_left;

	// Generator's own view of the last position and input word, so that
	// random requests can be shaped around them.
	logic [POS_W-1:0]  gen_pos;
	logic [WORD_W-1:0] gen_in;

	// Applies one request to the model and gives the result it must cause.
	function automatic ioc_result_t card_access_outcome(ioc_item_t req);
		ioc_result_t       res;
		logic [WORD_W-1:0] new_out;
		logic [WORD_W-1:0] fell;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  step;
		logic              any_irq;
		res = '0;
		any_irq = 1'b0;
		case (req.func)
			FUNC_WR_OUT: begin
				new_out = (req.data & req.write_mask) | (~req.write_mask & card_out);
				fell = card_out & ~new_out;
				for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
					if (fell[i]) begin
						card_edges[i] = card_edges[i] + WORD_W'(1);
					end
				end
				card_out = new_out;
			end
			FUNC_SET_IN: begin
				if ((req.data & card_mask) != (card_in & card_mask)) begin
					res.irq_digital_input = 1'b1;
					any_irq = 1'b1;
				end
				card_in = req.data;
			end
			FUNC_ENC_POS: begin
				pos = req.data[POS_W-1:0];
				step = pos - card_last_pos;
				// A forward step of the limit or more leaves the count alone.
				if (step < DIFF_LIMIT) begin
					card_count = card_count - CNT_W'(step);
					if (card_count > COUNT_LIMIT) begin
						card_ready = 1'b1;
						res.irq_encoder = 1'b1;
						any_irq = 1'b1;
					end
				end
				card_last_pos = pos;
			end
			FUNC_WR_CNT: begin
				// Writes to a counter other than the first are dropped whole.
				if (req.counter_select == SEL_COUNTER0) begin
					card_ready = 1'b0;
					card_count = req.data[CNT_W-1:0];
				end
			end
			FUNC_RD_CNT: begin
				if (req.counter_select == SEL_COUNTER0) begin
					res.read_data = WORD_W'(card_count);
				end
			end
			FUNC_RD_EDGE: begin
				if (int'(req.bit_index) < OUTPUT_CHANNELS) begin
					res.read_data = card_edges[req.bit_index];
				end
			end
			FUNC_RD_IN: begin
				res.read_data = card_in;
			end
			FUNC_PULSE: begin
				res.irq_pulse = 1'b1;
				any_irq = 1'b1;
			end
			default: begin
			end
		endcase
		// Any interrupt while the counter is ready also raises the encoder line.
		if (any_irq && card_ready) begin
			res.irq_encoder = 1'b1;
		end
		res.output_word = card_out;
		res.counter_ready = card_ready;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor. At each rising edge it first checks a result that is taken,
	// then records a mask write, then predicts for a request that is taken.
	// Doing all three in one process keeps the outcome free of any ordering
	// between processes within the time step.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ioc_result_t want;
		ioc_item_t   req;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none pending, actual rd=%h out=%h irq=%b%b%b rdy=%b",
						$time, read_data, output_word, irq_digital_input, irq_encoder,
						irq_pulse, counter_ready);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					compare_field("read_data", want.read_data, read_data);
					compare_field("output_word", want.output_word, output_word);
					compare_field("irq_digital_input", WORD_W'(want.irq_digital_input),
						WORD_W'(irq_digital_input));
					compare_field("irq_encoder", WORD_W'(want.irq_encoder),
						WORD_W'(irq_encoder));
					compare_field("irq_pulse", WORD_W'(want.irq_pulse),
						WORD_W'(irq_pulse));
					compare_field("counter_ready", WORD_W'(want.counter_ready),
						WORD_W'(counter_ready));
				end
			end
			if (cfg_write_en) begin
				card_mask = cfg_write_data;
			end
			if (in_valid && in_ready) begin
				req = '{func, data, write_mask, counter_select, bit_index};
				due_results.push_back(card_access_outcome(req));
			end
		end
	end

	// Cycle counter and overall time limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Random gap length: mostly none, sometimes short, rarely long.
	function automatic int idle_len(input bit enabled);
		int r;
		if (!enabled) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// ------------------------------------------------------------------
	// Receiver. It drives out_ready at each falling edge. A hold request
	// from a test starts a long hold-off that this process counts out on
	// its own, while the sender keeps offering requests.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		int g;
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (rx_gap_left > 0) begin
			out_ready <= 1'b0;
			rx_gap_left--;
		end else begin
			g = idle_len(rx_idle_on);
			if (g > 0) begin
				out_ready <= 1'b0;
				rx_gap_left = g - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender. Offers one request after an optional gap and returns at the
	// rising edge where it is taken. When no gap is drawn, valid simply
	// stays high and only the payload changes at the next falling edge.
	// ------------------------------------------------------------------
	task automatic send_request(input ioc_item_t req);
		int gap;
		gap = idle_len(tx_idle_on);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		func           <= req.func;
		data           <= req.data;
		write_mask     <= req.write_mask;
		counter_select <= req.counter_select;
		bit_index      <= req.bit_index;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	function automatic ioc_item_t request_of(input logic [FUNC_W-1:0] f,
			input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] m,
			input logic [SEL_W-1:0] s, input logic [BIT_W-1:0] b);
		ioc_item_t req;
		req = '{f, d, m, s, b};
		return req;
	endfunction

	// Lowers valid and waits until every pending result has been taken,
	// then SETTLE_CYCLES more rising edges so that the block is surely empty.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mask writes happen only once the block has drained.
	task automatic set_irq_mask(input logic [WORD_W-1:0] value);
		drain_pipeline();
		@(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
	endtask

	// Random request, weighted towards encoder samples near the last
	// position so that the counter runs down and ready is reached often.
	function automatic ioc_item_t pick_random_request();
		ioc_item_t req;
		int        r;
		int        k;
		req.data           = $urandom();
		req.write_mask     = $urandom();
		req.counter_select = ($urandom_range(0, 3) == 0) ? SEL_W'($urandom_range(1, 3))
			: SEL_COUNTER0;
		req.bit_index      = BIT_W'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		if (r < 15) begin
			req.func = FUNC_WR_OUT;
			k = $urandom_range(0, 3);
			if (k == 0) begin
				req.write_mask = '1;
			end else if (k == 1) begin
				req.write_mask = req.write_mask & $urandom();
			end
		end else if (r < 27) begin
			req.func = FUNC_SET_IN;
			k = $urandom_range(0, 3);
			if (k == 0) begin
				req.data = gen_in;
			end else if (k == 1) begin
				req.data = gen_in ^ (WORD_W'(1) << $urandom_range(0, 31));
			end
			gen_in = req.data;
		end else if (r < 52) begin
			req.func = FUNC_ENC_POS;
			k = $urandom_range(0, 99);
			if (k < 70) begin
				req.data[POS_W-1:0] = gen_pos + POS_W'($urandom_range(0, 300));
			end else if (k < 85) begin
				req.data[POS_W-1:0] = gen_pos + POS_W'($urandom_range(1995, 2005));
			end
			gen_pos = req.data[POS_W-1:0];
		end else if (r < 60) begin
			req.func = FUNC_WR_CNT;
			k = $urandom_range(0, 9);
			if (k < 5) begin
				req.data[CNT_W-1:0] = CNT_W'($urandom_range(0, 500));
			end else if (k < 7) begin
				req.data[CNT_W-1:0] = COUNT_LIMIT + CNT_W'($urandom_range(0, 1));
			end
		end else if (r < 70) begin
			req.func = FUNC_RD_CNT;
		end else if (r < 82) begin
			req.func = FUNC_RD_EDGE;
		end else if (r < 90) begin
			req.func = FUNC_RD_IN;
		end else begin
			req.func = FUNC_PULSE;
		end
		return req;
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Output writes at the extremes: full set, a partial and a full clear, an empty
	// mask, data outside the mask, and edge counts at both ends of the word.
	task automatic test_output_writes();
		send_request(request_of(FUNC_WR_OUT, '1, '1, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_WR_OUT, '0, 32'h0000_ffff, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_WR_OUT, '0, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_WR_OUT, '1, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_WR_OUT, '0, '1, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_RD_EDGE, '0, '0, SEL_COUNTER0, 5'd0));
		send_request(request_of(FUNC_RD_EDGE, '1, '1, 2'd3, 5'd31));
	endtask

	// Input changes with the mask clear and then fully set; a repeated word
	// must not interrupt.
	task automatic test_input_interrupts();
		send_request(request_of(FUNC_SET_IN, '1, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_RD_IN, '0, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_PULSE, '0, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_RD_CNT, '0, '0, SEL_COUNTER0, '0));
		set_irq_mask('1);
		send_request(request_of(FUNC_SET_IN, 32'hffff_fffe, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_SET_IN, 32'hffff_fffe, '0, SEL_COUNTER0, '0));
	endtask

	// Encoder: wrap of the count below zero, interrupts while ready, writes
	// and reads of a missing counter, a step at the limit and just below it,
	// wrap of the position, and a zero step.
	task automatic test_encoder_counter();
		send_request(request_of(FUNC_ENC_POS, 32'h0000_0005, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_PULSE, '0, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_SET_IN, '1, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_WR_CNT, 32'h0000_1234, '0, 2'd2, '0));
		send_request(request_of(FUNC_RD_CNT, '0, '0, 2'd3, '0));
		send_request(request_of(FUNC_WR_CNT, 32'hffff_8000, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_ENC_POS, 32'hffff_f000 | 32'd2005, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_ENC_POS, 32'd4004, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_ENC_POS, 32'd3, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_WR_CNT, '0, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_ENC_POS, 32'd3, '0, SEL_COUNTER0, '0));
		send_request(request_of(FUNC_RD_CNT, '0, '0, SEL_COUNTER0, '0));
		gen_pos = POS_W'(3);
		gen_in = '1;
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_request(pick_random_request());
	endtask

	// Receiver holds off for a long stretch while the sender keeps going,
	// so the block fills up and in_ready falls.
	task automatic test_backpressure();
		bit saved_tx;
		saved_tx = tx_idle_on;
		tx_idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (20) send_request(pick_random_request());
		tx_idle_on = saved_tx;
	endtask

	// A stretch at full rate with no gaps on either side.
	task automatic test_steady_stream(input int count);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (count) send_request(pick_random_request());
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		// Every input of the block starts at a known value.
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		func           = FUNC_WR_OUT;
		data           = '0;
		write_mask     = '0;
		counter_select = SEL_COUNTER0;
		bit_index      = '0;
		out_ready      = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_write_data = '0;

		// The model starts in the reset state of the card.
		card_mask     = '0;
		card_out      = '0;
		card_in       = '0;
		card_count    = '0;
		card_last_pos = '0;
		card_ready    = 1'b0;
		for (int i = 0; i < EDGE_DEPTH; i++) begin
			card_edges[i] = '0;
		end
		gen_pos      = '0;
		gen_in       = '0;
		mismatches   = 0;
		cycles       = 0;
		tx_idle_on   = 1'b1;
		rx_idle_on   = 1'b1;
		hold_request = 1'b0;
		hold_left    = 0;
		rx_gap_left  = 0;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_output_writes();
		test_input_interrupts();
		test_encoder_counter();

		set_irq_mask($urandom());
		test_random_traffic(250);
		test_backpressure();
		set_irq_mask(32'h8000_0001);
		test_random_traffic(200);
		test_steady_stream(80);
		set_irq_mask('0);
		test_random_traffic(170);
		set_irq_mask('1);
		test_backpressure();
		test_random_traffic(200);

		drain_pipeline();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
